// File: src/pbr_pkg.sv
// ----------------------------------------------------------------------------
// pbr_pkg - shared types and constants for the PCG32 bounded random block
// Command codes, sequencer states, unit handshake types, widths and the LCG multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package pbr_pkg;

    localparam int unsigned CMD_W   = 2;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned STATE_W = 64;
    localparam int unsigned STRM_W  = 63;

    localparam logic [STATE_W-1:0] LCG_MULT = 64'h5851_F42D_4C95_7F2D;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESEED  = 2'd0,
        CMD_RAW     = 2'd1,
        CMD_BOUNDED = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RS_ADV1,
        ST_RS_ADV2,
        ST_THRESH,
        ST_DRAW,
        ST_REDUCE,
        ST_EMIT
    } t_state;

    // handshake between the sequencer and a multi-cycle unit
    typedef struct packed {
        logic start;
    } t_unit_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

`default_nettype wire

// File: src/pbr_mod.sv
// ----------------------------------------------------------------------------
// pbr_mod - iterative 32-bit remainder unit
// Restoring division, one quotient bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module pbr_mod
    import pbr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_unit_req         i_req,
    input  wire logic [WORD_W-1:0] i_num,
    input  wire logic [WORD_W-1:0] i_den,
    output t_unit_stat             o_stat,
    output logic [WORD_W-1:0]      o_rem
);

    localparam int unsigned CNT_W = $clog2(WORD_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_num;
    logic [WORD_W-1:0] r_den;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;
    logic [WORD_W-1:0] n_rem;

    // one compare-and-subtract step
    always_comb begin
        trial = {r_rem, r_num[WORD_W-1]};
        diff  = trial - {1'b0, r_den};
        if (trial >= {1'b0, r_den}) begin
            n_rem = diff[WORD_W-1:0];
        end else begin
            n_rem = trial[WORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[WORD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

`default_nettype wire

// File: src/pbr_lcg.sv
// ----------------------------------------------------------------------------
// pbr_lcg - one LCG advance plus XSH-RR output permutation
// 64-bit state * multiplier mod 2^64 from three 32x32 partial products on one
// shared multiplier, then the increment is added.
// The increment is read at the last step and must hold steady while busy.
// ----------------------------------------------------------------------------
`default_nettype none

module pbr_lcg
    import pbr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_unit_req          i_req,
    input  wire logic [STATE_W-1:0] i_state,
    input  wire logic [STRM_W-1:0]  i_inc_hi,
    output t_unit_stat              o_stat,
    output logic [STATE_W-1:0]      o_next,
    output logic [WORD_W-1:0]       o_word
);

    localparam int unsigned HALF = STATE_W / 2;
    localparam logic [2:0]  LAST = 3'd4;

    logic                 r_busy;
    logic                 r_done;
    logic [2:0]           r_cnt;
    logic [STATE_W-1:0]   r_a;
    logic [STATE_W-1:0]   r_prod;
    logic [STATE_W-1:0]   r_acc;
    logic [WORD_W-1:0]    r_word;
    logic [HALF-1:0]      mul_a;
    logic [HALF-1:0]      mul_b;
    logic [STATE_W-1:0]   xs;
    logic [WORD_W-1:0]    mixed;
    logic [4:0]           amt;
    logic [2*WORD_W-1:0]  rot;

    // XSH-RR on the pre-advance state
    always_comb begin
        xs    = i_state ^ (i_state >> 18);
        mixed = xs[58:27];
        amt   = i_state[63:59];
        rot   = {mixed, mixed} >> amt;
    end

    // operand select for the shared multiplier
    always_comb begin
        case (r_cnt)
            3'd1: begin
                mul_a = r_a[HALF-1:0];
                mul_b = LCG_MULT[STATE_W-1:HALF];
            end
            3'd2: begin
                mul_a = r_a[STATE_W-1:HALF];
                mul_b = LCG_MULT[HALF-1:0];
            end
            default: begin
                mul_a = r_a[HALF-1:0];
                mul_b = LCG_MULT[HALF-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a    <= i_state;
            r_word <= rot[WORD_W-1:0];
        end else if (r_busy) begin
            r_prod <= mul_a * mul_b;
            case (r_cnt)
                3'd1:    r_acc <= r_prod;
                3'd2:    r_acc <= r_acc + {r_prod[HALF-1:0], {HALF{1'b0}}};
                3'd3:    r_acc <= r_acc + {r_prod[HALF-1:0], {HALF{1'b0}}};
                3'd4:    r_acc <= r_acc + {i_inc_hi, 1'b1};
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_next      = r_acc;
    assign o_word      = r_word;

endmodule

`default_nettype wire

// File: src/pcg32_bounded_random.sv
// ----------------------------------------------------------------------------
// pcg32_bounded_random - PCG32 (XSH-RR) generator with reseed, raw and
// bounded draws
// ----------------------------------------------------------------------------
// One command word in, one result word out. Work runs on two shared units
// under a small sequencer: an LCG unit (one 32x32 multiplier) and a
// restoring remainder unit. A bounded draw takes LCG outputs until one is
// not below the rejection threshold; bound zero and the unused command code
// go straight to the result register. The input side is ready only while
// the sequencer is idle; the result sits in an output register so a new
// command is taken while the previous result waits.
// Configuration: index 0 = seed (64 b), index 1 = stream select (63 b).
// Writes are always accepted and must land while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcg32_bounded_random
    import pbr_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // command word
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [39:0]  s_axis_tdata,  // [1:0] command, [33:2] bound, rest zero
    // result word
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [31:0]       m_axis_tdata,  // [31:0] value
    output logic              m_axis_tuser,  // [0] error
    // configuration write
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic         i_cfg_index,
    input  wire logic [63:0]  i_cfg_data
);

    localparam logic CFG_SEED   = 1'b0;
    localparam logic CFG_STREAM = 1'b1;

    // configuration and generator state
    logic [STATE_W-1:0] r_seed;
    logic [STRM_W-1:0]  r_stream;
    logic [STATE_W-1:0] r_state;
    logic [STRM_W-1:0]  r_inc_hi;     // increment = {r_inc_hi, 1}

    // sequencer
    t_state             r_fsm;
    t_state             n_fsm;
    logic               r_raw;
    logic [WORD_W-1:0]  r_bound;
    logic [WORD_W-1:0]  r_thresh;
    logic [WORD_W-1:0]  r_res_val;
    logic               r_res_err;

    // output register
    logic               r_ovalid;
    logic [WORD_W-1:0]  r_oval;
    logic               r_oerr;

    // unit hookup
    t_unit_req          lcg_req;
    t_unit_stat         lcg_stat;
    logic [STATE_W-1:0] lcg_in;
    logic [STATE_W-1:0] lcg_next;
    logic [WORD_W-1:0]  lcg_word;
    t_unit_req          mod_req;
    t_unit_stat         mod_stat;
    logic [WORD_W-1:0]  mod_num;
    logic [WORD_W-1:0]  mod_den;
    logic [WORD_W-1:0]  mod_rem;

    logic               in_acc;
    logic [CMD_W-1:0]   in_cmd;
    logic [WORD_W-1:0]  in_bound;
    logic               out_free;

    assign in_cmd   = s_axis_tdata[1:0];
    assign in_bound = s_axis_tdata[33:2];
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;

    // ---------------- next state ----------------
    always_comb begin
        n_fsm = r_fsm;
        case (r_fsm)
            ST_IDLE: begin
                if (in_acc) begin
                    case (in_cmd)
                        CMD_RESEED: n_fsm = ST_RS_ADV1;
                        CMD_RAW:    n_fsm = ST_DRAW;
                        CMD_BOUNDED: begin
                            if (in_bound == '0) begin
                                n_fsm = ST_EMIT;
                            end else begin
                                n_fsm = ST_THRESH;
                            end
                        end
                        default:    n_fsm = ST_EMIT;
                    endcase
                end
            end
            ST_RS_ADV1: if (lcg_stat.done) n_fsm = ST_RS_ADV2;
            ST_RS_ADV2: if (lcg_stat.done) n_fsm = ST_EMIT;
            ST_THRESH:  if (mod_stat.done) n_fsm = ST_DRAW;
            ST_DRAW: begin
                if (lcg_stat.done) begin
                    if (r_raw) begin
                        n_fsm = ST_EMIT;
                    end else if (lcg_word >= r_thresh) begin
                        n_fsm = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:  if (mod_stat.done) n_fsm = ST_EMIT;
            ST_EMIT:    if (out_free) n_fsm = ST_IDLE;
            default:    n_fsm = ST_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb begin
        s_axis_tready = 1'b0;
        lcg_req.start = 1'b0;
        lcg_in        = r_state;
        mod_req.start = 1'b0;
        mod_num       = lcg_word;
        mod_den       = r_bound;
        case (r_fsm)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_acc) begin
                    case (in_cmd)
                        CMD_RESEED: begin
                            lcg_req.start = 1'b1;
                            lcg_in        = '0;
                        end
                        CMD_RAW: lcg_req.start = 1'b1;
                        CMD_BOUNDED: begin
                            // threshold = (2^32 - bound) mod bound
                            mod_req.start = (in_bound != '0);
                            mod_num       = '0 - in_bound;
                            mod_den       = in_bound;
                        end
                        default: lcg_req.start = 1'b0;
                    endcase
                end
            end
            ST_RS_ADV1: begin
                lcg_req.start = lcg_stat.done;
                lcg_in        = lcg_next + r_seed;
            end
            ST_THRESH: lcg_req.start = mod_stat.done;
            ST_DRAW: begin
                lcg_in = lcg_next;
                if (lcg_stat.done && !r_raw) begin
                    // redraw while below threshold, else reduce
                    lcg_req.start = (lcg_word < r_thresh);
                    mod_req.start = (lcg_word >= r_thresh);
                end
            end
            default: s_axis_tready = 1'b0;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_seed   <= 64'd1;
            r_stream <= '0;
            r_state  <= '0;
            r_inc_hi <= '0;
        end else begin
            r_fsm <= n_fsm;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SEED:   r_seed   <= i_cfg_data;
                    CFG_STREAM: r_stream <= i_cfg_data[STRM_W-1:0];
                    default:    r_seed   <= r_seed;
                endcase
            end
            if (in_acc && in_cmd == CMD_RESEED) begin
                r_inc_hi <= r_stream;
            end
            if (lcg_stat.done && (r_fsm == ST_RS_ADV2 || r_fsm == ST_DRAW)) begin
                r_state <= lcg_next;
            end
            if (r_fsm == ST_EMIT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_raw     <= (in_cmd == CMD_RAW);
            r_bound   <= in_bound;
            r_res_val <= '0;
            r_res_err <= (in_cmd == CMD_BOUNDED) && (in_bound == '0);
        end
        if (r_fsm == ST_THRESH && mod_stat.done) begin
            r_thresh <= mod_rem;
        end
        if (r_fsm == ST_DRAW && lcg_stat.done && r_raw) begin
            r_res_val <= lcg_word;
        end
        if (r_fsm == ST_REDUCE && mod_stat.done) begin
            r_res_val <= mod_rem;
        end
        if (r_fsm == ST_EMIT && out_free) begin
            r_oval <= r_res_val;
            r_oerr <= r_res_err;
        end
    end

    // ---------------- shared units ----------------
    pbr_lcg u_lcg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (lcg_req),
        .i_state  (lcg_in),
        .i_inc_hi (r_inc_hi),
        .o_stat   (lcg_stat),
        .o_next   (lcg_next),
        .o_word   (lcg_word)
    );

    pbr_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .i_num   (mod_num),
        .i_den   (mod_den),
        .o_stat  (mod_stat),
        .o_rem   (mod_rem)
    );

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_oval;
    assign m_axis_tuser  = r_oerr;

    // ---------------- assertions ----------------
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("error result carries nonzero value");

    a_units_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(lcg_stat.busy && mod_stat.busy))
        else $error("LCG and remainder units busy together");

    a_reduce_lt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fsm == ST_REDUCE && mod_stat.done |-> mod_rem < r_bound)
        else $error("bounded result not below bound");

    a_draw_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fsm == ST_DRAW && lcg_stat.done |=> r_state == $past(lcg_next))
        else $error("state not advanced after draw");

endmodule

`default_nettype wire
